@@ rtl/core/pbre_pkg.sv @@
// Shared widths and constants of the PackBits row encoder.
package pbre_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 8;
   localparam int COUNT_W    = 4;
   localparam int TOTAL_W    = 16;
   localparam int WORD_LANES = 8;
   localparam int WORD_W     = WORD_LANES * BYTE_W;

   // shortest run that becomes a replicate packet; also the lookahead a packet waits for
   localparam logic [LEN_W-1:0]   RUN_MIN   = LEN_W'(3);
   localparam logic [LEN_W-1:0]   LOOKAHEAD = LEN_W'(3);
   // window holds one packet plus its lookahead plus the arriving byte
   localparam int                 WINDOW_SLACK = 4;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

@@ rtl/core/pbre_ifs.sv @@
// Valid/ready channel interfaces for the row byte input and the packet word output.
interface pbre_req_if;
   import pbre_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              row_end;

   modport source (output valid, data_byte, row_end, input ready);
   modport sink   (input valid, data_byte, row_end, output ready);
endinterface

interface pbre_rsp_if;
   import pbre_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  packed_bytes;
   logic [COUNT_W-1:0] byte_count;
   logic               packet_end;
   logic               row_done;
   logic [TOTAL_W-1:0] row_packed_length;

   modport source (output valid, packed_bytes, byte_count, packet_end, row_done,
                   row_packed_length, input ready);
   modport sink   (input valid, packed_bytes, byte_count, packet_end, row_done,
                   row_packed_length, output ready);
endinterface

@@ rtl/core/packbits_row_encoder.sv @@
// A row byte passes through accept and evaluate when no packet closes on it.
// A closing packet then streams one packet byte per cycle from the window memory's single
//   read port, unless the output register stalls it: header plus payload for a literal,
//   header and byte for a replicate; a row end may add a tail packet, set up in ST_NEXT.
// A new row byte is taken only when idle, so a stalled output word holds the input too.
// Reset: synchronous, active high; clears pointers, counters, handshake state, not the memory.
module packbits_row_encoder #(
   parameter int MAX_PACKET_BYTES = 128,
   parameter int WORD_BYTES       = 8
) (
   input  logic       clock,
   input  logic       reset,
   pbre_req_if.sink   req_chan,
   pbre_rsp_if.source rsp_chan
);
   import pbre_pkg::*;

   // Window of pending bytes: circular buffer, oldest byte at head.
   localparam int                 DEPTH      = MAX_PACKET_BYTES + WINDOW_SLACK;
   localparam int                 AW         = $clog2(DEPTH);
   localparam logic [AW-1:0]      PTR_LAST   = AW'(DEPTH - 1);
   localparam logic [AW:0]        DEPTH_EXT  = (AW+1)'(DEPTH);
   localparam logic [LEN_W-1:0]   MAX_LEN    = LEN_W'(MAX_PACKET_BYTES);
   // a literal that never meets a run closes once it is full and its lookahead is in
   localparam logic [LEN_W-1:0]   FULL_COUNT = LEN_W'(MAX_PACKET_BYTES + 3);
   localparam logic [COUNT_W-1:0] LANE_LAST  = COUNT_W'(WORD_BYTES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;  // taking the next row byte
   localparam logic [1:0] ST_EVAL = 2'd1;  // decide whether the head packet closes
   localparam logic [1:0] ST_SEND = 2'd2;  // one packet byte per cycle into the word unless the output stalls
   localparam logic [1:0] ST_NEXT = 2'd3;  // set up the tail packet at row end

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                            input logic [LEN_W-1:0] n);
      logic [AW:0] s;
      s = {1'b0, p} + (AW+1)'(n);
      if (s >= DEPTH_EXT) s = s - DEPTH_EXT;
      return s[AW-1:0];
   endfunction

   // Replicate header is 257 - len mod 256, literal header is len - 1.
   function automatic logic [BYTE_W-1:0] pkt_header(input logic rep,
                                                    input logic [LEN_W-1:0] n);
      return rep ? (BYTE_W'(1) - BYTE_W'(n)) : (BYTE_W'(n) - BYTE_W'(1));
   endfunction

   // ---------------- state ----------------
   logic [1:0]          state_ff, state_in;

   logic [BYTE_W-1:0]   win_mem [DEPTH];
   logic [BYTE_W-1:0]   rd_q_ff;           // always mem[cur_ff]

   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [AW-1:0]       cur_ff, cur_in;    // next literal payload address
   logic [LEN_W-1:0]    win_count_ff, win_count_in;
   logic [LEN_W-1:0]    run_ff, run_in;    // leading bytes equal to the first one
   logic [BYTE_W-1:0]   first_ff, first_in;
   logic [BYTE_W-1:0]   b1_ff, b1_in;      // newest byte
   logic [BYTE_W-1:0]   b2_ff, b2_in;
   logic [BYTE_W-1:0]   b3_ff, b3_in;
   logic                end_ff, end_in;

   // packet being sent
   logic                pkt_rep_ff, pkt_rep_in;
   logic [LEN_W-1:0]    pkt_len_ff, pkt_len_in;
   logic [BYTE_W-1:0]   pkt_hdr_ff, pkt_hdr_in;
   logic [BYTE_W-1:0]   pkt_byte_ff, pkt_byte_in;
   logic                pkt_last_ff, pkt_last_in;  // closes the row
   logic                pkt_more_ff, pkt_more_in;  // tail packet follows
   logic [LEN_W-1:0]    pos_ff, pos_in;            // 0 is the header
   logic                tl_rep_ff, tl_rep_in;
   logic [1:0]          tl_len_ff, tl_len_in;

   // word assembly and output register
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]   out_word_ff, out_word_in;
   logic [COUNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic                out_pend_ff, out_pend_in;
   logic                out_done_ff, out_done_in;
   logic [TOTAL_W-1:0]  out_len_ff, out_len_in;

   // ---------------- evaluation terms ----------------
   logic                acc;
   logic                trip;        // last three window bytes equal
   logic                is_rep;
   logic                emit_now;
   logic [LEN_W-1:0]    cut_len;     // all but the lookahead
   logic [LEN_W-1:0]    first_len;   // head packet length at row end
   logic [LEN_W-1:0]    rest_len;
   logic [LEN_W-1:0]    restart_run;
   logic [LEN_W-1:0]    tail_len;

   // ---------------- sender terms ----------------
   logic [BYTE_W-1:0]   cur_byte;
   logic                last_byte;
   logic                word_done;
   logic                take;
   logic                load_out;
   logic [WORD_W-1:0]   lane_word;
   logic [TOTAL_W:0]    total_sum;
   logic [TOTAL_W-1:0]  total_sat;

   assign acc = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.packed_bytes      = out_word_ff;
   assign rsp_chan.byte_count        = out_cnt_ff;
   assign rsp_chan.packet_end        = out_pend_ff;
   assign rsp_chan.row_done          = out_done_ff;
   assign rsp_chan.row_packed_length = out_len_ff;

   // A packet that closes outside a row end leaves exactly the lookahead in the window,
   // so the head packet length is then count - 3.
   always_comb begin
      trip     = (win_count_ff >= RUN_MIN) && (b1_ff == b2_ff) && (b2_ff == b3_ff);
      is_rep   = (run_ff >= RUN_MIN);
      cut_len  = win_count_ff - LOOKAHEAD;
      if (is_rep) begin
         emit_now = (win_count_ff == run_ff + LOOKAHEAD);
      end else begin
         emit_now = (trip && win_count_ff > LOOKAHEAD) || (win_count_ff == FULL_COUNT);
      end
      // row end: head packet, then at most three bytes left over
      if (is_rep) begin
         first_len = run_ff;
      end else if (trip && win_count_ff > LOOKAHEAD) begin
         first_len = cut_len;
      end else begin
         first_len = (win_count_ff > MAX_LEN) ? MAX_LEN : win_count_ff;
      end
      rest_len = win_count_ff - first_len;
      // run length of the three bytes kept after a close (b3 oldest)
      restart_run = LEN_W'(1);
      if (b2_ff == b3_ff) begin
         restart_run = (b1_ff == b3_ff) ? RUN_MIN : LEN_W'(2);
      end
      tail_len = tl_rep_ff ? RUN_MIN : LEN_W'(tl_len_ff);
   end

   // Sender: one packet byte per cycle; the byte that completes a word goes straight
   // into the output register, so it waits when that register is still occupied.
   always_comb begin
      if (pos_ff == '0) begin
         cur_byte = pkt_hdr_ff;
      end else if (pkt_rep_ff) begin
         cur_byte = pkt_byte_ff;
      end else begin
         cur_byte = rd_q_ff;
      end
      last_byte = pkt_rep_ff ? (pos_ff == LEN_W'(1)) : (pos_ff == pkt_len_ff);
      word_done = last_byte || (cnt_ff == LANE_LAST);
      take      = (state_ff == ST_SEND) && (!word_done || !out_valid_ff || rsp_chan.ready);
      load_out  = take && word_done;
      lane_word = word_ff;
      for (int k = 0; k < WORD_LANES; k++) begin
         if (COUNT_W'(k) == cnt_ff) lane_word[k*BYTE_W +: BYTE_W] = cur_byte;
      end
      total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(cnt_ff + COUNT_W'(1));
      total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      win_count_in = win_count_ff;
      run_in       = run_ff;
      first_in     = first_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      end_in       = end_ff;
      pkt_rep_in   = pkt_rep_ff;
      pkt_len_in   = pkt_len_ff;
      pkt_hdr_in   = pkt_hdr_ff;
      pkt_byte_in  = pkt_byte_ff;
      pkt_last_in  = pkt_last_ff;
      pkt_more_in  = pkt_more_ff;
      pos_in       = pos_ff;
      tl_rep_in    = tl_rep_ff;
      tl_len_in    = tl_len_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      out_word_in  = out_word_ff;
      out_cnt_in   = out_cnt_ff;
      out_pend_in  = out_pend_ff;
      out_done_in  = out_done_ff;
      out_len_in   = out_len_ff;
      out_valid_in = rsp_chan.ready ? 1'b0 : out_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               tail_in      = ptr_inc(tail_ff);
               win_count_in = win_count_ff + LEN_W'(1);
               b1_in        = req_chan.data_byte;
               b2_in        = b1_ff;
               b3_in        = b2_ff;
               end_in       = req_chan.row_end;
               if (win_count_ff == '0) begin
                  first_in = req_chan.data_byte;
                  run_in   = LEN_W'(1);
               end else if (run_ff == win_count_ff && run_ff < MAX_LEN &&
                            req_chan.data_byte == first_ff) begin
                  run_in = run_ff + LEN_W'(1);
               end
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            pkt_rep_in  = is_rep;
            pkt_byte_in = first_ff;
            pos_in      = '0;
            cur_in      = head_ff;
            if (end_ff) begin
               // row end: flush everything, at most two packets
               pkt_len_in   = first_len;
               pkt_hdr_in   = pkt_header(is_rep, first_len);
               pkt_last_in  = (rest_len == '0);
               pkt_more_in  = (rest_len != '0);
               tl_rep_in    = (rest_len == RUN_MIN) && trip;
               tl_len_in    = rest_len[1:0];
               head_in      = ptr_add(head_ff, first_len);
               win_count_in = '0;
               run_in       = '0;
               state_in     = ST_SEND;
            end else if (emit_now) begin
               pkt_len_in   = cut_len;
               pkt_hdr_in   = pkt_header(is_rep, cut_len);
               pkt_last_in  = 1'b0;
               pkt_more_in  = 1'b0;
               head_in      = ptr_add(head_ff, cut_len);
               win_count_in = LOOKAHEAD;
               first_in     = b3_ff;
               run_in       = restart_run;
               state_in     = ST_SEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NEXT: begin
            pkt_rep_in  = tl_rep_ff;
            pkt_len_in  = tail_len;
            pkt_hdr_in  = pkt_header(tl_rep_ff, tail_len);
            pkt_byte_in = b1_ff;
            pkt_last_in = 1'b1;
            pkt_more_in = 1'b0;
            pos_in      = '0;
            cur_in      = head_ff;
            head_in     = tail_ff;
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            if (take) begin
               pos_in = last_byte ? '0 : pos_ff + LEN_W'(1);
               if (pos_ff != '0 && !pkt_rep_ff) cur_in = ptr_inc(cur_ff);
               if (word_done) begin
                  out_valid_in = 1'b1;
                  out_word_in  = lane_word;
                  out_cnt_in   = cnt_ff + COUNT_W'(1);
                  out_pend_in  = last_byte;
                  out_done_in  = last_byte && pkt_last_ff;
                  out_len_in   = total_sat;
                  total_in     = (last_byte && pkt_last_ff) ? '0 : total_sat;
                  word_in      = '0;
                  cnt_in       = '0;
               end else begin
                  word_in = lane_word;
                  cnt_in  = cnt_ff + COUNT_W'(1);
               end
               if (last_byte) state_in = pkt_more_ff ? ST_NEXT : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_out) out_valid_in = 1'b1;
   end

   // Window memory: one write port (accept), one registered read port (sender).
   always_ff @(posedge clock) begin
      if (acc) win_mem[tail_ff] <= req_chan.data_byte;
      rd_q_ff <= win_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cur_ff       <= '0;
         win_count_ff <= '0;
         run_ff       <= '0;
         end_ff       <= 1'b0;
         pkt_last_ff  <= 1'b0;
         pkt_more_ff  <= 1'b0;
         pos_ff       <= '0;
         word_ff      <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         win_count_ff <= win_count_in;
         run_ff       <= run_in;
         end_ff       <= end_in;
         pkt_last_ff  <= pkt_last_in;
         pkt_more_ff  <= pkt_more_in;
         pos_ff       <= pos_in;
         word_ff      <= word_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      pkt_rep_ff  <= pkt_rep_in;
      pkt_len_ff  <= pkt_len_in;
      pkt_hdr_ff  <= pkt_hdr_in;
      pkt_byte_ff <= pkt_byte_in;
      tl_rep_ff   <= tl_rep_in;
      tl_len_ff   <= tl_len_in;
      out_word_ff <= out_word_in;
      out_cnt_ff  <= out_cnt_in;
      out_pend_ff <= out_pend_in;
      out_done_ff <= out_done_in;
      out_len_ff  <= out_len_in;
   end

endmodule

@@ rtl/core/pbre_checker.sv @@
// Port-level assertions on the packet word channel, bound to the row encoder.
module pbre_checker #(
   parameter int WORD_BYTES = 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pbre_pkg::WORD_W-1:0]   rsp_packed_bytes,
   input logic [pbre_pkg::COUNT_W-1:0]  rsp_byte_count,
   input logic                          rsp_packet_end,
   input logic                          rsp_row_done,
   input logic [pbre_pkg::TOTAL_W-1:0]  rsp_row_packed_length
);
   import pbre_pkg::*;

   logic               row_start_ff;   // next transaction opens a row
   logic [TOTAL_W-1:0] prev_len_ff;
   logic [TOTAL_W:0]   len_sum;
   logic [TOTAL_W-1:0] len_expect;
   logic               upper_clean;

   always_comb begin
      len_sum = {1'b0, prev_len_ff} + (TOTAL_W+1)'(rsp_byte_count);
      if (row_start_ff) begin
         len_expect = TOTAL_W'(rsp_byte_count);
      end else begin
         len_expect = len_sum[TOTAL_W] ? TOTAL_MAX : len_sum[TOTAL_W-1:0];
      end
      upper_clean = 1'b1;
      for (int k = 0; k < WORD_LANES; k++) begin
         if (COUNT_W'(k) >= rsp_byte_count && rsp_packed_bytes[k*BYTE_W +: BYTE_W] != '0)
            upper_clean = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_start_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         row_start_ff <= rsp_row_done;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) prev_len_ff <= rsp_row_packed_length;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_bytes) &&
                                  $stable(rsp_byte_count) && $stable(rsp_row_packed_length))
      else $error("result word changed while stalled");

   a_word_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count != '0 && rsp_byte_count <= COUNT_W'(WORD_BYTES) &&
                    upper_clean)
      else $error("byte count out of range or stray bytes above it");

   a_row_done_closes_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done |-> rsp_packet_end)
      else $error("row done on a word that does not end a packet");

   a_length_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_row_packed_length == len_expect)
      else $error("row packed length does not accumulate byte counts");

endmodule

bind packbits_row_encoder pbre_checker #(.WORD_BYTES(WORD_BYTES)) u_pbre_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_packed_bytes      (rsp_chan.packed_bytes),
   .rsp_byte_count        (rsp_chan.byte_count),
   .rsp_packet_end        (rsp_chan.packet_end),
   .rsp_row_done          (rsp_chan.row_done),
   .rsp_row_packed_length (rsp_chan.row_packed_length)
);
